// ----- sv/htbm_pkg.sv -----
// htbm_pkg: shared constants, types and codes for the height to bump map unit
// used by htbm_div and height_to_bump_map_unit; depends on nothing else
package htbm_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 11;
    localparam int MASK_W    = 24;
    localparam int HGT_W     = 10;
    localparam int ALPHA_W   = 8;
    localparam int CTR_W     = HGT_W + ALPHA_W;
    localparam int PROD_W    = HGT_W + ALPHA_W;
    localparam int DIVD_W    = 18;
    localparam int DIVS_W    = 10;
    localparam int LANES     = 3;
    localparam int CNT_W     = $clog2(DIVD_W + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] BYTE_FULL = 8'hff;
    localparam logic [7:0] BYTE_BIAS = 8'h80;
    localparam logic [7:0] SCALE_ONE = 8'd255;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_BY_ALPHA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_OUTPUT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd3;

    // opcodes on the input tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [DIVD_W-1:0] t_divd;
    typedef t_divd [LANES-1:0] t_lanes;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_MUL,
        S_SCL,
        S_DSTART,
        S_DIV,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_BODY,
        PH_FLUSH
    } t_phase;

endpackage

// ----- sv/height_to_bump_map_unit.sv -----
// height_to_bump_map_unit: raster height map in, central-difference bump map out
// depends on htbm_pkg and htbm_div
//
// Pixels arrive in raster order and the bump map of row j leaves while row j+1
// comes in; flush beats (tuser = 1) drain the last row, whose lower neighbor is
// row 0. Three row stores with one read port each hold row 0, the row above and
// the row being emitted. A row-0 pixel, and a beat that is dropped (a flush
// during row 0, a pixel while flushing), is taken without leaving S_IDLE. A
// beat that yields a result passes, after its acceptance, through S_RD0 to
// S_RD3, which read its own entry and both row neighbors through the single
// read ports, S_MUL and S_SCL, which multiply and scale by alpha/255,
// S_DSTART, which loads the bit-serial divider, and S_DIV for its 18 steps
// and done flag, which turn the three values into multiples of
// 255/divisor, and S_OUT, which hands the result to the output register;
// with an all-zero channel mask the divider is skipped. A beat waits in
// S_OUT while the receiver leaves the output register full. The stores need
// no clearing pass after reset. Configuration writes are accepted in every
// cycle and must only be issued while no beat is in flight.
module height_to_bump_map_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [htbm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [htbm_pkg::MASK_W-1:0]    i_cfg_data,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [31:0]                    i_s_tdata,   // pixel_in
    input  logic                           i_s_tuser,   // opcode
    // output stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [31:0]                    o_m_tdata,   // pixel_out
    output logic                           o_m_tlast    // last_of_frame
);
    import htbm_pkg::*;

    // configuration
    logic [MASK_W-1:0] r_mask;
    logic              r_scale;
    logic              r_bias;
    logic [WID_W-1:0]  r_width;

    // control
    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_out_valid;
    logic [31:0]       r_out_data;
    logic              r_out_last;

    // item context
    logic              r_op;
    logic [COL_W-1:0]  r_c;
    logic [COL_W-1:0]  r_wlast;
    logic              r_last;
    logic [HGT_W-1:0]  r_ph;
    logic [ALPHA_W-1:0] r_pa;
    logic [HGT_W-1:0]  r_ch;
    logic [ALPHA_W-1:0] r_ca;
    logic [HGT_W-1:0]  r_up;
    logic [HGT_W-1:0]  r_down;
    logic [HGT_W-1:0]  r_left;
    logic [HGT_W-1:0]  r_right;
    logic [PROD_W-1:0] r_prod;
    logic [HGT_W-1:0]  r_hg;
    logic              r_dx_neg, r_dy_neg;
    logic [HGT_W-1:0]  r_dx_mag, r_dy_mag;

    // row stores
    logic [HGT_W-1:0]  first_mem  [MAX_WIDTH];
    logic [HGT_W-1:0]  upper_mem  [MAX_WIDTH];
    logic [CTR_W-1:0]  center_mem [MAX_WIDTH];
    logic [HGT_W-1:0]  r_first_q, r_upper_q;
    logic [CTR_W-1:0]  r_center_q;
    logic [COL_W-1:0]  upper_ra, center_ra;
    logic [COL_W-1:0]  wr_addr;
    logic              we_first, we_upper, we_center;
    logic [HGT_W-1:0]  wd_upper;
    logic [CTR_W-1:0]  wd_center;

    // input side decode
    logic [WID_W-1:0]  eff_w;
    logic [COL_W-1:0]  cur_c;
    logic              cur_last;
    logic [HGT_W-1:0]  in_h;
    logic [ALPHA_W-1:0] in_a;
    logic              in_acc;
    logic              in_emit;
    logic              in_first;
    logic              out_free;
    logic [DIVS_W-1:0] divis;

    // arithmetic
    logic [PROD_W:0]   sc_sum;
    logic [WID_W-1:0]  sc_q0;
    logic [PROD_W:0]   sc_rem;
    logic [HGT_W:0]    dx_s, dy_s;
    logic              div_start, div_done;
    t_lanes            div_dvd, div_quo;
    logic [7:0]        hb, xb, yb, bb;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= {MASK_W{1'b1}};
            r_scale <= 1'b0;
            r_bias  <= 1'b0;
            r_width <= WID_W'(MAX_WIDTH);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CHANNEL_MASK:   r_mask  <= i_cfg_data;
                REG_SCALE_BY_ALPHA: r_scale <= i_cfg_data[0];
                REG_BIAS_OUTPUT:    r_bias  <= i_cfg_data[0];
                REG_IMAGE_WIDTH:    r_width <= i_cfg_data[WID_W-1:0];
            endcase
        end
    end

    assign divis = DIVS_W'(r_mask[7:0]) + DIVS_W'(r_mask[15:8]) + DIVS_W'(r_mask[23:16]);

    always_comb begin
        if (r_width == '0) begin
            eff_w = WID_W'(1);
        end else if (r_width > WID_W'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = r_width;
        end
    end

    // a counter left beyond a narrowed row is taken as the last column
    assign cur_c    = (WID_W'(r_col) >= eff_w) ? COL_W'(eff_w - WID_W'(1)) : r_col;
    assign cur_last = (WID_W'(cur_c) == eff_w - WID_W'(1));

    assign in_h = HGT_W'(i_s_tdata[7:0] & r_mask[7:0])
                + HGT_W'(i_s_tdata[15:8] & r_mask[15:8])
                + HGT_W'(i_s_tdata[23:16] & r_mask[23:16]);
    assign in_a = i_s_tdata[31:24];

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign in_first   = (i_s_tuser == OP_PIXEL) && (r_phase == PH_FIRST);
    assign in_emit    = ((i_s_tuser == OP_PIXEL) && (r_phase == PH_BODY))
                     || ((i_s_tuser == OP_FLUSH) && (r_phase != PH_FIRST));
    assign out_free   = !r_out_valid || i_m_tready;

    // next state, store addressing and write control
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_col     = r_col;
        upper_ra  = r_c;
        center_ra = r_c;
        wr_addr   = r_c;
        we_first  = 1'b0;
        we_upper  = 1'b0;
        we_center = 1'b0;
        wd_upper  = r_ch;
        wd_center = {r_pa, r_ph};
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                wr_addr = cur_c;
                if (in_acc && in_first) begin
                    // row 0 goes straight into the stores
                    we_first  = 1'b1;
                    we_upper  = 1'b1;
                    we_center = 1'b1;
                    wd_upper  = in_h;
                    wd_center = {in_a, in_h};
                    if (cur_last) begin
                        n_col   = '0;
                        n_phase = PH_BODY;
                    end else begin
                        n_col = cur_c + COL_W'(1);
                    end
                end else if (in_acc && in_emit) begin
                    n_state = S_RD0;
                end
            end
            S_RD0: n_state = S_RD1;
            S_RD1: begin
                center_ra = r_wlast;
                upper_ra  = r_c - COL_W'(1);
                n_state   = S_RD2;
            end
            S_RD2: begin
                center_ra = r_c + COL_W'(1);
                upper_ra  = '0;
                n_state   = S_RD3;
            end
            S_RD3: n_state = S_MUL;
            S_MUL: n_state = S_SCL;
            S_SCL: n_state = (divis == '0) ? S_OUT : S_DSTART;
            S_DSTART: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: if (div_done) n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    we_upper  = 1'b1;
                    we_center = (r_op == OP_PIXEL);
                    n_state   = S_IDLE;
                    if (r_last) begin
                        n_col   = '0;
                        n_phase = (r_op == OP_PIXEL) ? PH_BODY : PH_FIRST;
                    end else begin
                        n_col   = r_c + COL_W'(1);
                        n_phase = (r_op == OP_PIXEL) ? PH_BODY : PH_FLUSH;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_FIRST;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_col   <= n_col;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // row stores, one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (we_first) first_mem[wr_addr] <= wd_upper;
        r_first_q <= first_mem[r_c];
    end

    always_ff @(posedge i_clk) begin
        if (we_upper) upper_mem[wr_addr] <= wd_upper;
        r_upper_q <= upper_mem[upper_ra];
    end

    always_ff @(posedge i_clk) begin
        if (we_center) center_mem[wr_addr] <= wd_center;
        r_center_q <= center_mem[center_ra];
    end

    // scale by alpha/255: reciprocal estimate, low by at most one
    assign sc_sum = {1'b0, r_prod} + (PROD_W+1)'(r_prod >> 8);
    assign sc_q0  = sc_sum[PROD_W:8];
    assign sc_rem = {1'b0, r_prod} - (((PROD_W+1)'(sc_q0) << 8) - (PROD_W+1)'(sc_q0));

    assign dx_s = {1'b0, r_left} - {1'b0, r_right};
    assign dy_s = {1'b0, r_down} - {1'b0, r_up};

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_s_tuser;
            r_c     <= cur_c;
            r_wlast <= COL_W'(eff_w - WID_W'(1));
            r_last  <= cur_last;
            r_ph    <= in_h;
            r_pa    <= in_a;
        end
        unique case (r_state)
            S_RD1: begin
                r_ch   <= r_center_q[HGT_W-1:0];
                r_ca   <= r_center_q[CTR_W-1:HGT_W];
                r_up   <= r_upper_q;
                r_down <= (r_op == OP_FLUSH) ? r_first_q : r_ph;
            end
            S_RD2: begin
                r_left <= (r_c == '0) ? r_center_q[HGT_W-1:0] : r_upper_q;
            end
            S_RD3: begin
                if (r_last) begin
                    r_right <= (r_c == '0) ? r_ch : r_upper_q;
                end else begin
                    r_right <= r_center_q[HGT_W-1:0];
                end
            end
            S_MUL: begin
                r_prod   <= PROD_W'(r_ch) * PROD_W'(r_scale ? r_ca : SCALE_ONE);
                r_dx_neg <= dx_s[HGT_W];
                r_dx_mag <= dx_s[HGT_W] ? HGT_W'(-dx_s) : dx_s[HGT_W-1:0];
                r_dy_neg <= dy_s[HGT_W];
                r_dy_mag <= dy_s[HGT_W] ? HGT_W'(-dy_s) : dy_s[HGT_W-1:0];
            end
            S_SCL: begin
                r_hg <= (sc_rem >= (PROD_W+1)'(SCALE_ONE)) ? HGT_W'(sc_q0 + WID_W'(1))
                                                          : HGT_W'(sc_q0);
            end
            default: ;
        endcase
    end

    // times 255 as shift and subtract
    assign div_dvd[0] = (DIVD_W'(r_hg) << 8) - DIVD_W'(r_hg);
    assign div_dvd[1] = (DIVD_W'(r_dx_mag) << 8) - DIVD_W'(r_dx_mag);
    assign div_dvd[2] = (DIVD_W'(r_dy_mag) << 8) - DIVD_W'(r_dy_mag);

    htbm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (divis),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        if (divis == '0) begin
            hb = '0;
            xb = '0;
            yb = '0;
        end else begin
            hb = div_quo[0][7:0];
            xb = r_dx_neg ? 8'(8'd0 - div_quo[1][7:0]) : div_quo[1][7:0];
            yb = r_dy_neg ? 8'(8'd0 - div_quo[2][7:0]) : div_quo[2][7:0];
        end
        bb = BYTE_FULL;
        if (r_bias) begin
            xb = xb + BYTE_BIAS;
            yb = yb + BYTE_BIAS;
            bb = bb + BYTE_BIAS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_data <= {hb, xb, yb, bb};
            r_out_last <= (r_op == OP_FLUSH) && r_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// ----- sv/htbm_div.sv -----
// htbm_div: three-lane restoring divider sharing one divisor, one bit a cycle
// depends on htbm_pkg
module htbm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  htbm_pkg::t_lanes            i_dividend,
    input  logic [htbm_pkg::DIVS_W-1:0] i_divisor,
    output logic                        o_done,
    output htbm_pkg::t_lanes            o_quotient
);
    import htbm_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIVS_W-1:0]   r_dvs;
    t_lanes              r_quo;
    logic [DIVS_W-1:0]   r_rem [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DIVS_W:0] trial;
        if (i_start) begin
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
            for (int k = 0; k < LANES; k++) begin
                r_rem[k] <= '0;
            end
        end else if (r_busy) begin
            for (int k = 0; k < LANES; k++) begin
                trial = {r_rem[k], r_quo[k][DIVD_W-1]};
                if (trial >= {1'b0, r_dvs}) begin
                    r_rem[k] <= DIVS_W'(trial - {1'b0, r_dvs});
                    r_quo[k] <= {r_quo[k][DIVD_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[DIVS_W-1:0];
                    r_quo[k] <= {r_quo[k][DIVD_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- sim/height_to_bump_map_unit_test.sv -----
// height_to_bump_map_unit_test: random and directed stream test of the bump map unit
// keeps its own model of the row stores and checks every output beat against it
// depends on htbm_pkg and height_to_bump_map_unit
`timescale 1ns / 1ps

module height_to_bump_map_unit_test;
    import htbm_pkg::*;

    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_BEATS    = 150;

    class bump_map_checker;
        typedef struct packed {
            logic [31:0] pixel;
            logic        last;
        } t_bump_beat;

        logic [MASK_W-1:0] mask;
        logic              alpha_scale;
        logic              bias;
        logic [WID_W-1:0]  width_reg;

        logic [HGT_W-1:0] row0_height [MAX_WIDTH];
        logic [HGT_W-1:0] above_height [MAX_WIDTH];
        logic [CTR_W-1:0] middle_entry [MAX_WIDTH];
        int unsigned      col;
        t_phase           phase;

        t_bump_beat pending_bumps[$];
        int         mismatches;

        function void restart();
            mask        = {MASK_W{1'b1}};
            alpha_scale = 1'b0;
            bias        = 1'b0;
            width_reg   = WID_W'(MAX_WIDTH);
            col         = 0;
            phase       = PH_FIRST;
            mismatches  = 0;
            pending_bumps.delete();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [MASK_W-1:0] value);
            case (index)
                REG_CHANNEL_MASK:   mask = value;
                REG_SCALE_BY_ALPHA: alpha_scale = value[0];
                REG_BIAS_OUTPUT:    bias = value[0];
                REG_IMAGE_WIDTH:    width_reg = value[WID_W-1:0];
                default:            ;
            endcase
        endfunction

        // central differences for column c of the middle row, then it becomes the row above
        function logic [31:0] bump_pixel(int unsigned c, int unsigned w, int unsigned down);
            int unsigned here, alpha, up, lft, rgt, divisor, weight, hgt;
            int          dx, dy;
            logic [7:0]  hb, xb, yb, bb;
            here    = 32'(middle_entry[c][HGT_W-1:0]);
            alpha   = 32'(middle_entry[c][CTR_W-1:HGT_W]);
            up      = 32'(above_height[c]);
            divisor = 32'(mask[7:0]) + 32'(mask[15:8]) + 32'(mask[23:16]);
            if (c == 0) begin
                lft = 32'(middle_entry[w-1][HGT_W-1:0]);
            end else begin
                lft = 32'(above_height[c-1]);
            end
            if (c == w - 1) begin
                rgt = (c == 0) ? here : 32'(above_height[0]);
            end else begin
                rgt = 32'(middle_entry[c+1][HGT_W-1:0]);
            end
            hb = 8'h00;
            xb = 8'h00;
            yb = 8'h00;
            bb = BYTE_FULL;
            if (divisor != 0) begin
                weight = alpha_scale ? alpha : 255;
                hgt    = (here * weight) / 255;
                hgt    = (hgt * 255) / divisor;
                dx     = ((int'(lft) - int'(rgt)) * 255) / int'(divisor);
                dy     = ((int'(down) - int'(up)) * 255) / int'(divisor);
                hb     = 8'(hgt);
                xb     = 8'(dx);
                yb     = 8'(dy);
            end
            if (bias) begin
                xb += BYTE_BIAS;
                yb += BYTE_BIAS;
                bb += BYTE_BIAS;
            end
            above_height[c] = HGT_W'(here);
            return {hb, xb, yb, bb};
        endfunction

        function void take_source_beat(logic op, logic [31:0] pix);
            int unsigned       w, c, h;
            logic [MASK_W-1:0] m;
            logic              at_end;
            t_bump_beat        beat;
            if (width_reg == '0) begin
                w = 1;
            end else if (int'(width_reg) > MAX_WIDTH) begin
                w = MAX_WIDTH;
            end else begin
                w = 32'(width_reg);
            end
            c      = (col >= w) ? w - 1 : col;
            at_end = (c == w - 1);
            if (op == OP_PIXEL) begin
                if (phase == PH_FLUSH) return;
                m = pix[23:0] & mask;
                h = 32'(m[7:0]) + 32'(m[15:8]) + 32'(m[23:16]);
                if (phase == PH_FIRST) begin
                    row0_height[c]  = HGT_W'(h);
                    above_height[c] = HGT_W'(h);
                end else begin
                    beat.pixel = bump_pixel(c, w, h);
                    beat.last  = 1'b0;
                    pending_bumps.push_back(beat);
                end
                middle_entry[c] = {pix[31:24], HGT_W'(h)};
                if (at_end) begin
                    col   = 0;
                    phase = PH_BODY;
                end else begin
                    col = c + 1;
                end
            end else begin
                if (phase == PH_FIRST) return;
                // the row below the last row is row 0
                beat.pixel = bump_pixel(c, w, 32'(row0_height[c]));
                beat.last  = at_end;
                pending_bumps.push_back(beat);
                if (at_end) begin
                    col   = 0;
                    phase = PH_FIRST;
                end else begin
                    col   = c + 1;
                    phase = PH_FLUSH;
                end
            end
        endfunction

        function void check_bump_beat(logic [31:0] pix, logic last);
            t_bump_beat want;
            if (pending_bumps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat: pixel %08h last %0b", pix, last);
                return;
            end
            want = pending_bumps.pop_front();
            if (pix !== want.pixel || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("output beat mismatch: pixel expected %08h got %08h, last %0b got %0b",
                             want.pixel, pix, want.last, last);
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [MASK_W-1:0]    i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [31:0]          i_s_tdata   = '0;   // pixel_in
    logic                 i_s_tuser   = OP_PIXEL;   // opcode
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [31:0]          o_m_tdata;          // pixel_out
    logic                 o_m_tlast;          // last_of_frame

    bump_map_checker sb = new;
    int src_idle   = 0;
    int sink_stall = 0;
    int hold_left  = 0;
    int beats_sent = 0;
    int quiet      = 0;

    height_to_bump_map_unit dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold-off counted down here
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= sink_stall);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) sb.take_source_beat(i_s_tuser, i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_bump_beat(o_m_tdata, o_m_tlast);
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("height_to_bump_map_unit_test failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_pixel();
        logic [31:0] p;
        p = $urandom;
        // a quarter of the pixels use only empty or saturated bytes
        if ($urandom_range(3) == 0) p = {{8{p[31]}}, {8{p[23]}}, {8{p[15]}}, {8{p[7]}}};
        return p;
    endfunction

    function automatic logic [MASK_W-1:0] rand_mask();
        case ($urandom_range(5))
            0:       return {MASK_W{1'b1}};
            1:       return '0;
            2:       return MASK_W'($urandom);
            3:       return MASK_W'(24'hff << (8 * $urandom_range(2)));
            4:       return MASK_W'($urandom_range(1, 3));
            default: return MASK_W'($urandom & $urandom);
        endcase
    endfunction

    task automatic send_beat(input logic op, input logic [31:0] data);
        while ($urandom_range(99) < src_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= data;
        do @(posedge i_clk); while (!o_s_tready);
        beats_sent++;
    endtask

    // leaves valid high so back-to-back writes need no gap
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [MASK_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(index, value);
    endtask

    task automatic program_regs(input logic [MASK_W-1:0] mask, input logic alpha,
                                input logic bias, input logic [WID_W-1:0] width);
        cfg_write(REG_CHANNEL_MASK, mask);
        cfg_write(REG_SCALE_BY_ALPHA, MASK_W'(alpha));
        cfg_write(REG_BIAS_OUTPUT, MASK_W'(bias));
        cfg_write(REG_IMAGE_WIDTH, MASK_W'(width));
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every expected beat is out and the unit has gone quiet
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_bumps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one frame of w columns; a body row may be cut short by an early flush
    task automatic send_frame(input int w, input int rows);
        int cut;
        int r;
        int c;
        cut = w;
        for (r = 0; r < rows && cut == w; r++) begin
            if (r > 0 && w > 1 && $urandom_range(5) == 0) cut = int'($urandom_range(1, w - 1));
            for (c = 0; c < cut; c++) begin
                // stray flush while row 0 fills is dropped
                if (r == 0 && $urandom_range(19) == 0) send_beat(OP_FLUSH, $urandom);
                send_beat(OP_PIXEL, rand_pixel());
            end
        end
        for (c = 0; c < w - cut % w; c++) begin
            // stray pixel while flushing is dropped
            if (c > 0 && $urandom_range(19) == 0) send_beat(OP_PIXEL, rand_pixel());
            send_beat(OP_FLUSH, $urandom);
        end
    endtask

    initial begin
        int start;
        logic [WID_W-1:0] w_reg;
        sb.restart();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two full rows, with a dropped flush and a dropped pixel
        settle();
        program_regs(24'hffffff, 1'b0, 1'b0, 11'd3);
        send_beat(OP_FLUSH, 32'hffffffff);
        send_beat(OP_PIXEL, 32'hffffffff);
        send_beat(OP_PIXEL, 32'h00000000);
        send_beat(OP_PIXEL, 32'h80ff00ff);
        send_beat(OP_PIXEL, 32'h00ffffff);
        send_beat(OP_PIXEL, 32'hff000000);
        send_beat(OP_PIXEL, 32'h7f7f7f7f);
        send_beat(OP_FLUSH, 32'h00000000);
        send_beat(OP_PIXEL, 32'h12345678);
        send_beat(OP_FLUSH, 32'hffffffff);
        send_beat(OP_FLUSH, 32'h00000000);

        // flush in the middle of a body row, alpha scaling and bias on
        settle();
        program_regs(24'h0f0f0f, 1'b1, 1'b1, 11'd3);
        send_beat(OP_PIXEL, 32'h40ffffff);
        send_beat(OP_PIXEL, 32'hff0f0f0f);
        send_beat(OP_PIXEL, 32'h00ffffff);
        send_beat(OP_PIXEL, 32'hffffffff);
        send_beat(OP_FLUSH, 32'h00000000);
        send_beat(OP_FLUSH, 32'h00000000);

        // width shrinks below the column count in the middle of row 0
        settle();
        program_regs(24'hffffff, 1'b0, 1'b0, 11'd5);
        send_beat(OP_PIXEL, 32'hff102030);
        send_beat(OP_PIXEL, 32'hff000000);
        send_beat(OP_PIXEL, 32'hffffffff);
        send_beat(OP_PIXEL, 32'h80808080);
        settle();
        cfg_write(REG_IMAGE_WIDTH, MASK_W'(2));
        i_cfg_valid <= 1'b0;
        send_beat(OP_PIXEL, 32'h00ff00ff);
        send_beat(OP_FLUSH, 32'h00000000);
        send_beat(OP_FLUSH, 32'h00000000);

        // zero divisor on a single-column frame
        settle();
        program_regs(24'h000000, 1'b1, 1'b1, 11'd1);
        send_beat(OP_PIXEL, 32'hffffffff);
        send_beat(OP_PIXEL, 32'h00000000);
        send_beat(OP_FLUSH, 32'hffffffff);

        // width 0 behaves as 1; divisor of one wraps the bytes
        settle();
        program_regs(24'h000001, 1'b0, 1'b0, 11'd0);
        send_beat(OP_PIXEL, 32'hffffffff);
        send_beat(OP_PIXEL, 32'h00000001);
        send_beat(OP_FLUSH, 32'h00000000);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin src_idle = 0;  sink_stall = 0;  end
                1:       begin src_idle = 50; sink_stall = 0;  end
                2:       begin src_idle = 0;  sink_stall = 50; end
                default: begin src_idle = 30; sink_stall = 30; end
            endcase
            if (ph == 0) begin
                // receiver holds off so the unit backs up into its input
                settle();
                program_regs(rand_mask(), 1'($urandom_range(1)), 1'($urandom_range(1)), 11'd8);
                hold_left = HOLD_CYCLES;
                send_frame(8, 3);
            end
            start = beats_sent;
            while (beats_sent - start < PHASE_BEATS) begin
                w_reg = ($urandom_range(7) == 0) ? WID_W'($urandom_range(9, 40))
                                                 : WID_W'($urandom_range(1, 8));
                settle();
                program_regs(rand_mask(), 1'($urandom_range(1)), 1'($urandom_range(1)), w_reg);
                send_frame(int'(w_reg), int'($urandom_range(1, 4)));
            end
            if (ph == 0) begin
                // width register past the maximum, then narrowed in the middle of row 0
                settle();
                program_regs(rand_mask(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                             11'd2047);
                for (int c = 0; c < 11; c++) send_beat(OP_PIXEL, rand_pixel());
                settle();
                cfg_write(REG_IMAGE_WIDTH, MASK_W'(12));
                i_cfg_valid <= 1'b0;
                for (int c = 0; c < 13; c++) send_beat(OP_PIXEL, rand_pixel());
                for (int c = 0; c < 12; c++) send_beat(OP_FLUSH, $urandom);
            end
        end

        settle();
        if (sb.mismatches == 0 && sb.pending_bumps.size() == 0) begin
            $display("height_to_bump_map_unit_test passed");
        end else begin
            $display("height_to_bump_map_unit_test failed");
        end
        $finish;
    end

endmodule
